### src/ffrm_pkg.sv
// ----------------------------------------------------------------------------
// ffrm_pkg
// Shared types and codes for the first-fit resource map: the fragment entry
// layout, operation codes and result status codes.
// ----------------------------------------------------------------------------
package ffrm_pkg;

  // one fragment of the free map
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } frag_t;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  // operation codes
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_LOST  = 2'd2;

endpackage

### src/ffrm_map_mem.sv
// ----------------------------------------------------------------------------
// ffrm_map_mem
// Fragment table storage: one write port, one read port with registered
// data. A fill mark tracks the highest slot written since the last clear;
// slots above it read as empty fragments.
// ----------------------------------------------------------------------------
module ffrm_map_mem #(
  parameter int ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
  output ffrm_pkg::frag_t              rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
  input  ffrm_pkg::frag_t              wr_data
);
  import ffrm_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  frag_t         mem [ENTRIES];
  frag_t         q_r;
  logic          vld_r;
  logic [IW:0]   fill_r;

  // storage write and registered read with write-through
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      q_r <= wr_data;
    end else begin
      q_r <= mem[rd_addr];
    end
  end

  // fill mark and read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      vld_r <= ({1'b0, rd_addr} < fill_r) || (wr_en && (wr_addr == rd_addr));
      if (clr) begin
        fill_r <= '0;
      end else if (wr_en && ({1'b0, wr_addr} >= fill_r)) begin
        fill_r <= {1'b0, wr_addr} + 1'b1;
      end
    end
  end

  // slots at or above the fill mark read as empty
  assign rd_data = vld_r ? q_r : '0;

  a_fill_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> fill_r == '0)
    else $error("fill mark not cleared");

endmodule

### src/first_fit_resource_map.sv
// ----------------------------------------------------------------------------
// first_fit_resource_map
// First-fit allocator over a sorted table of free fragments.
//
// Usage: an item on the in_ channel carries an op (alloc, free, clear),
// a size and a free address. One result item per input item leaves on the
// out_ channel: the allocated address, a status and the free-unit total.
// The cfg_ channel writes track_free (cfg_data); write it while idle.
// The sequencer walks the table one slot per cycle through the
// single read port of the fragment memory, prefetching the next slot. The
// result is registered after the scan and shift steps; clear and the unused
// op go straight to the finish state.
// One item is worked on at a time; the next is taken once the result is
// in the output register, and it is accepted while that result still
// waits on a stalled receiver. A stalled receiver holds the next result
// in the sequencer until the output register frees.
// Reset empties the map at once through the memory's fill mark, zeroes
// the free total and sets track_free.
// ----------------------------------------------------------------------------
module first_fit_resource_map #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffrm_pkg::op_t       in_op,
  input  logic [31:0]         in_size,
  input  logic [31:0]         in_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_alloc_addr,
  output ffrm_pkg::status_t   out_status,
  output logic [31:0]         out_free_units,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import ffrm_pkg::*;

  localparam int          IW       = $clog2(ENTRIES);
  localparam logic [IW:0] LAST_IDX = (IW+1)'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ASCAN, S_FSCAN, S_REM, S_INS, S_LASTZ, S_FIN
  } state_t;

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [IW:0] idx_r, idx_nxt;
  frag_t       prev_r, prev_nxt;
  frag_t       carry_r, carry_nxt;
  status_t     stat_r, stat_nxt;
  logic [31:0] res_r, res_nxt;
  logic        upd_r, upd_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic        lost_end_r, lost_end_nxt;
  logic        track_r;
  logic [31:0] total_r;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  status_t     out_status_r;

  logic          mem_clr;
  logic [IW-1:0] rd_addr;
  frag_t         cur;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  frag_t         wr_data;

  logic [IW:0]   idx_p1, idx_p2, idx_m1;
  logic          at_last, cont, below, above;

  ffrm_map_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mem_clr),
    .rd_addr (rd_addr),
    .rd_data (cur),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign idx_p1  = idx_r + 1'b1;
  assign idx_p2  = idx_r + (IW+1)'(2);
  assign idx_m1  = idx_r - 1'b1;
  assign at_last = (idx_r == LAST_IDX);
  assign cont    = (cur.length != '0) && (cur.start <= addr_r);
  assign below   = (idx_r != '0) && ((prev_r.start + prev_r.length) == addr_r);
  assign above   = (cur.length != '0) && ((addr_r + size_r) == cur.start);

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_status_r;
  assign out_free_units = total_r;

  // sequencer: scan, write back, shift
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    size_nxt     = size_r;
    addr_nxt     = addr_r;
    idx_nxt      = idx_r;
    prev_nxt     = prev_r;
    carry_nxt    = carry_r;
    stat_nxt     = stat_r;
    res_nxt      = res_r;
    upd_nxt      = upd_r;
    pend_nxt     = pend_r;
    lost_end_nxt = lost_end_r;
    mem_clr      = 1'b0;
    rd_addr      = idx_p1[IW-1:0];
    wr_en        = 1'b0;
    wr_addr      = idx_r[IW-1:0];
    wr_data      = cur;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          op_nxt       = in_op;
          size_nxt     = in_size;
          addr_nxt     = in_addr;
          idx_nxt      = '0;
          stat_nxt     = ST_OK;
          res_nxt      = '0;
          upd_nxt      = 1'b0;
          pend_nxt     = '0;
          lost_end_nxt = 1'b0;
          priority if (in_op == OP_ALLOC) begin
            state_nxt = S_ASCAN;
          end else if (in_op == OP_FREE) begin
            state_nxt = S_FSCAN;
          end else if (in_op == OP_CLEAR) begin
            mem_clr   = 1'b1;
            upd_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      // first fit search
      S_ASCAN: begin
        if (cur.length == '0) begin
          stat_nxt  = ST_NOFIT;
          state_nxt = S_FIN;
        end else if (cur.length >= size_r) begin
          res_nxt        = cur.start;
          upd_nxt        = 1'b1;
          pend_nxt       = total_r - size_r;
          wr_data.start  = cur.start + size_r;
          wr_data.length = cur.length - size_r;
          if ((wr_data.length != '0) || at_last) begin
            wr_en     = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_REM;
          end
        end else if (at_last) begin
          wr_en          = 1'b1;
          wr_data.length = '0;
          stat_nxt       = ST_NOFIT;
          state_nxt      = S_FIN;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      // find the insert point of a freed range
      S_FSCAN: begin
        pend_nxt = total_r + size_r;
        if (cont) begin
          if (at_last) begin
            wr_en          = 1'b1;
            wr_data.length = '0;
            stat_nxt       = ST_LOST;
            state_nxt      = S_FIN;
          end else begin
            prev_nxt = cur;
            idx_nxt  = idx_p1;
          end
        end else if (below) begin
          wr_en         = 1'b1;
          wr_addr       = idx_m1[IW-1:0];
          wr_data.start = prev_r.start;
          upd_nxt       = 1'b1;
          if (above) begin
            wr_data.length = prev_r.length + size_r + cur.length;
            lost_end_nxt   = 1'b1;
            carry_nxt      = cur;
            state_nxt      = at_last ? S_LASTZ : S_REM;
          end else begin
            wr_data.length = prev_r.length + size_r;
            state_nxt      = S_FIN;
          end
        end else if (above) begin
          wr_en          = 1'b1;
          wr_data.start  = cur.start - size_r;
          wr_data.length = cur.length + size_r;
          upd_nxt        = 1'b1;
          state_nxt      = S_FIN;
        end else if (size_r != '0) begin
          wr_en         = 1'b1;
          wr_data.start = addr_r;
          carry_nxt     = cur;
          if (at_last) begin
            wr_data.length = '0;
            stat_nxt       = ST_LOST;
            state_nxt      = S_FIN;
          end else begin
            wr_data.length = size_r;
            upd_nxt        = 1'b1;
            if (cur.length == '0) begin
              state_nxt = S_FIN;
            end else begin
              idx_nxt   = idx_p1;
              state_nxt = S_INS;
            end
          end
        end else begin
          upd_nxt   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      // close the gap: slot idx takes the slot above it
      S_REM: begin
        rd_addr = idx_p2[IW-1:0];
        wr_en   = 1'b1;
        if (cur.length == '0) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_p1;
          carry_nxt = cur;
          if (idx_p1 == LAST_IDX) begin
            state_nxt = S_LASTZ;
          end
        end
      end
      // table end reached while shifting
      S_LASTZ: begin
        wr_en          = 1'b1;
        wr_addr        = LAST_IDX[IW-1:0];
        wr_data.start  = carry_r.start;
        wr_data.length = '0;
        if (lost_end_r) begin
          stat_nxt = ST_LOST;
          upd_nxt  = 1'b0;
        end
        state_nxt = S_FIN;
      end
      // ripple the later fragments up one slot
      S_INS: begin
        wr_en         = 1'b1;
        wr_data       = carry_r;
        carry_nxt     = cur;
        if (at_last) begin
          wr_data.length = '0;
          stat_nxt       = ST_LOST;
          upd_nxt        = 1'b0;
          state_nxt      = S_FIN;
        end else if (cur.length == '0) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // state, result register and free total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      track_r     <= 1'b1;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        track_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        if (upd_r && track_r) begin
          total_r <= pend_r;
        end
      end
    end
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    carry_r    <= carry_nxt;
    stat_r     <= stat_nxt;
    res_r      <= res_nxt;
    upd_r      <= upd_nxt;
    pend_r     <= pend_nxt;
    lost_end_r <= lost_end_nxt;
    if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
      out_addr_r   <= res_r;
      out_status_r <= stat_r;
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start");

  a_rem_writes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REM) || (state_r == S_INS) || (state_r == S_LASTZ)) |-> wr_en)
    else $error("shift step without write");

  a_nofit_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_addr_r == '0))
    else $error("failed item reports an address");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit resource map. A class keeps its own
// copy of the fragment table and free total, predicts the result of every
// accepted item and compares each result item field by field. Stimulus is a
// short directed list, then random alloc/free/clear and unused-op traffic,
// mostly over a narrow address window, with bursts that overflow the table,
// under track_free on, off and on again, and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ffrm_pkg::*;

  localparam int ENTRIES = 64;
  localparam op_t OP_NONE = 2'd3;

  typedef struct {
    logic [31:0] addr;
    status_t     status;
    logic [31:0] total;
  } map_result_t;

  // predictor of the fragment map and store of pending results
  class frag_map_scoreboard;
    logic [31:0] start_tbl [ENTRIES];
    logic [31:0] len_tbl [ENTRIES];
    logic [31:0] free_total;
    bit          track;
    map_result_t pending_results[$];
    int          errors;

    function new();
      foreach (start_tbl[k]) begin
        start_tbl[k] = '0;
        len_tbl[k] = '0;
      end
      free_total = '0;
      track = 1'b1;
      errors = 0;
    endfunction

    // close the gap at slot k; 0 if the end of table was hit
    function bit close_slot(int k);
      for (int j = k; j < ENTRIES; j++) begin
        if (j + 1 < ENTRIES) begin
          start_tbl[j] = start_tbl[j + 1];
          len_tbl[j] = len_tbl[j + 1];
          if (len_tbl[j] == 0) return 1'b1;
        end else begin
          len_tbl[j] = '0;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function status_t carve(logic [31:0] sz, output logic [31:0] got);
      int i;
      bit dummy;
      i = 0;
      got = '0;
      while (i < ENTRIES && len_tbl[i] != 0) begin
        if (len_tbl[i] >= sz) begin
          got = start_tbl[i];
          start_tbl[i] += sz;
          len_tbl[i] -= sz;
          if (len_tbl[i] == 0) dummy = close_slot(i);
          if (track) free_total -= sz;
          return ST_OK;
        end
        i++;
      end
      if (i >= ENTRIES) len_tbl[ENTRIES - 1] = '0;
      return ST_NOFIT;
    endfunction

    function status_t give_back(logic [31:0] sz, logic [31:0] a);
      int i;
      logic [31:0] carry_a, carry_s, t;
      i = 0;
      while (i < ENTRIES && len_tbl[i] != 0 && start_tbl[i] <= a) i++;
      if (i >= ENTRIES) begin
        len_tbl[ENTRIES - 1] = '0;
        return ST_LOST;
      end
      if (i > 0 && start_tbl[i - 1] + len_tbl[i - 1] == a) begin
        // merge below, maybe above too
        len_tbl[i - 1] += sz;
        if (len_tbl[i] != 0 && a + sz == start_tbl[i]) begin
          len_tbl[i - 1] += len_tbl[i];
          if (!close_slot(i)) return ST_LOST;
        end
      end else if (len_tbl[i] != 0 && a + sz == start_tbl[i]) begin
        start_tbl[i] -= sz;
        len_tbl[i] += sz;
      end else if (sz != 0) begin
        // insert in order, ripple later fragments up
        carry_a = a;
        carry_s = sz;
        do begin
          t = start_tbl[i];
          start_tbl[i] = carry_a;
          carry_a = t;
          t = len_tbl[i];
          len_tbl[i] = carry_s;
          carry_s = t;
          i++;
        end while (carry_s != 0 && i < ENTRIES);
        if (i >= ENTRIES) begin
          len_tbl[ENTRIES - 1] = '0;
          return ST_LOST;
        end
      end
      if (track) free_total += sz;
      return ST_OK;
    endfunction

    function void note_request(op_t op, logic [31:0] sz, logic [31:0] a);
      map_result_t r;
      r.addr = '0;
      r.status = ST_OK;
      case (op)
        OP_ALLOC: r.status = carve(sz, r.addr);
        OP_FREE: r.status = give_back(sz, a);
        OP_CLEAR: begin
          foreach (start_tbl[k]) begin
            start_tbl[k] = '0;
            len_tbl[k] = '0;
          end
          if (track) free_total = '0;
        end
        default: ;
      endcase
      r.total = free_total;
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [31:0] a, status_t st, logic [31:0] tot);
      map_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item addr=%h status=%0d free=%h", $time, a, st, tot);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (a !== e.addr) begin
        $display("%0t: alloc_addr expected %h actual %h", $time, e.addr, a);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (tot !== e.total) begin
        $display("%0t: free_units expected %h actual %h", $time, e.total, tot);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  op_t         in_op;
  logic [31:0] in_size;
  logic [31:0] in_addr;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_alloc_addr;
  status_t     out_status;
  logic [31:0] out_free_units;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  frag_map_scoreboard sb;
  bit steady;
  bit hold_req;

  first_fit_resource_map #(.ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_size(in_size), .in_addr(in_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_alloc_addr(out_alloc_addr), .out_status(out_status),
    .out_free_units(out_free_units),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // accepted items on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_op, in_size, in_addr);
    if (rst_n && out_valid && out_ready)
      sb.check_response(out_alloc_addr, out_status, out_free_units);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = steady || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] sz, logic [31:0] a);
    if (!steady && $urandom_range(99) < 29) repeat ($urandom_range(1, 4)) @(negedge clk);
    in_valid = 1'b1;
    in_op = op;
    in_size = sz;
    in_addr = a;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait until every result is back, then let the sequencer settle
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (140) @(negedge clk);
  endtask

  task automatic write_track(bit v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.track = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_items(int n);
    int pick;
    logic [31:0] sz, a;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      sz = $urandom_range(1, 40);
      a = $urandom_range(0, 3000);
      if (pick < 8) begin
        sz = $urandom();
        a = $urandom();
      end
      if (pick < 40) send_item(OP_ALLOC, sz, a);
      else if (pick < 95) send_item(OP_FREE, sz, a);
      else if (pick < 97) send_item(OP_CLEAR, sz, a);
      else if (pick < 99) send_item(OP_NONE, sz, a);
      else send_item(OP_FREE, 0, a);
    end
  endtask

  // scattered frees that run past the end of the table
  task automatic overflow_burst();
    int base;
    base = $urandom_range(0, 500);
    for (int k = 0; k < 72; k++)
      send_item(OP_FREE, $urandom_range(1, 4), base + 10 * k + $urandom_range(0, 3) * 0);
    for (int k = 0; k < 12; k++) send_item(OP_ALLOC, $urandom_range(1, 6), 0);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ALLOC;
    in_size = '0;
    in_addr = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty map, merges, exact fits, wrap, unused op, clear
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 5, 0);
    send_item(OP_FREE, 10, 100);
    send_item(OP_FREE, 5, 120);
    send_item(OP_FREE, 10, 110);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 25, 0);
    send_item(OP_FREE, 50, 50);
    send_item(OP_FREE, 10, 40);
    send_item(OP_FREE, 0, 7);
    send_item(OP_FREE, 20, 200);
    send_item(OP_FREE, 0, 100);
    send_item(OP_FREE, 32'h20, 32'hFFFF_FFF0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 0);
    send_item(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 60, 0);
    send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_FREE, 32'hAAAA_5555, 32'h5555_AAAA);
    send_item(OP_ALLOC, 32'h5555_AAAA, 0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // phase with tracking on, fill past the table end
    random_items(150);
    overflow_burst();
    hold_req = 1'b1;
    random_items(60);
    drain();

    // tracking frozen
    write_track(1'b0);
    random_items(150);
    overflow_burst();
    steady = 1'b1;
    random_items(80);
    steady = 1'b0;
    drain();

    // tracking back on
    write_track(1'b1);
    send_item(OP_CLEAR, 0, 0);
    random_items(200);
    drain();

    while (sb.pending_results.size() != 0 || hold_req) @(posedge clk);
    repeat (140) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
src/ffrm_pkg.sv
src/ffrm_map_mem.sv
src/first_fit_resource_map.sv
tb/tb_top.sv
